@@ rtl/tagged_record_field_extractor_defines.svh @@
// assertion macros used by the extractor top level
`ifndef TAGGED_RECORD_FIELD_EXTRACTOR_DEFINES_SVH
`define TAGGED_RECORD_FIELD_EXTRACTOR_DEFINES_SVH

// condition implies consequence in the same cycle
`define TRE_ASSERT_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define TRE_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tre_pkg.sv @@
// types, codes and tag table for the tagged record field extractor
package tre_pkg;

  localparam logic [2:0] KIND_BATTERY     = 3'd0;
  localparam logic [2:0] KIND_TEMPERATURE = 3'd1;
  localparam logic [2:0] KIND_RSSI        = 3'd2;
  localparam logic [2:0] KIND_SWITCH      = 3'd3;
  localparam logic [2:0] KIND_VOLTAGE     = 3'd4;
  localparam logic [2:0] KIND_CURRENT     = 3'd5;
  localparam logic [2:0] KIND_TRUNCATED   = 3'd6;

  localparam logic [7:0] TAG_BATTERY     = 8'h01;
  localparam logic [7:0] TAG_TEMPERATURE = 8'h03;
  localparam logic [7:0] TAG_RSSI        = 8'h05;
  localparam logic [7:0] TAG_SWITCH1     = 8'h64;
  localparam logic [7:0] TAG_SWITCH2     = 8'h65;
  localparam logic [7:0] TAG_VOLTAGE     = 8'h96;
  localparam logic [7:0] TAG_CURRENT     = 8'h97;

  localparam logic [15:0] RSSI_OFFSET = 16'd90;

  localparam logic [1:0] CHANNEL_ONE = 2'd1;
  localparam logic [1:0] CHANNEL_TWO = 2'd2;

  typedef struct packed {
    logic        in_field;
    logic [7:0]  field_tag;
    logic [2:0]  bytes_left;
    logic [2:0]  byte_position;
    logic [31:0] value_accumulator;
  } parse_state_t;

  typedef struct packed {
    logic [2:0]         report_kind;
    logic [1:0]         channel;
    logic [31:0]        value_raw;
    logic signed [15:0] rssi_dbm;
    logic               mains_powered;
  } report_t;

  // bytes that follow a tag: one type byte plus the value
  function automatic logic [2:0] tag_length(input logic [7:0] tag);
    logic [2:0] len;
    case (tag)
      8'h03, 8'h0c, 8'h64, 8'h65, 8'h6e, 8'h6f, 8'h94, 8'h9c: len = 3'd2;
      8'h01, 8'h04, 8'h05, 8'h08, 8'h09, 8'h0a, 8'h9b:        len = 3'd3;
      8'h95, 8'h96, 8'h97, 8'h98:                             len = 3'd5;
      8'h06:                                                  len = 3'd6;
      default:                                                len = 3'd0;
    endcase
    return len;
  endfunction

endpackage

@@ rtl/tre_decode.sv @@
// per-byte parse step: next state and report for one payload byte
module tre_decode
  import tre_pkg::*;
(
  input  parse_state_t state,
  input  logic [7:0]   payload_byte,
  input  logic         last_byte,
  output parse_state_t state_next,
  output logic         fire,
  output report_t      report
);

  logic [2:0]  len;
  logic [2:0]  pos;
  logic [2:0]  left;
  logic [4:0]  shamt;
  logic [31:0] acc;
  logic [15:0] rssi_raw;

  assign len      = tag_length(payload_byte);
  assign pos      = state.byte_position + 3'd1;
  assign left     = state.bytes_left - 3'd1;
  assign shamt    = {pos - 3'd2, 2'b00} << 1;
  assign rssi_raw = acc[15:0] - RSSI_OFFSET;

  always_comb begin
    acc = state.value_accumulator;
    if (pos inside {[3'd2:3'd5]}) begin
      acc = state.value_accumulator | ({24'd0, payload_byte} << shamt);
    end
  end

  always_comb begin
    state_next = state;
    fire       = 1'b0;
    report     = '{report_kind: KIND_TRUNCATED, channel: CHANNEL_ONE,
                   value_raw: 32'd0, rssi_dbm: 16'sd0, mains_powered: 1'b0};

    if (!state.in_field) begin
      if (len != 3'd0) begin
        state_next = '{in_field: 1'b1, field_tag: payload_byte, bytes_left: len,
                       byte_position: 3'd0, value_accumulator: 32'd0};
      end
    end else begin
      state_next.byte_position     = pos;
      state_next.bytes_left        = left;
      state_next.value_accumulator = acc;
      if (left == 3'd0) begin
        state_next = '0;
        fire       = 1'b1;
        case (state.field_tag)
          TAG_BATTERY: begin
            report.report_kind = KIND_BATTERY;
            report.value_raw   = {16'd0, acc[15:0]};
          end
          TAG_TEMPERATURE: begin
            report.report_kind = KIND_TEMPERATURE;
            report.value_raw   = {24'd0, payload_byte};
          end
          TAG_RSSI: begin
            report.report_kind = KIND_RSSI;
            report.rssi_dbm    = rssi_raw;
          end
          TAG_SWITCH1, TAG_SWITCH2: begin
            report.report_kind = KIND_SWITCH;
            report.channel     = (state.field_tag == TAG_SWITCH2) ? CHANNEL_TWO : CHANNEL_ONE;
            report.value_raw   = {31'd0, payload_byte == 8'd1};
          end
          TAG_VOLTAGE: begin
            report.report_kind   = KIND_VOLTAGE;
            report.value_raw     = acc;
            report.mains_powered = 1'b1;
          end
          TAG_CURRENT: begin
            report.report_kind = KIND_CURRENT;
            report.value_raw   = acc;
          end
          default: fire = 1'b0;
        endcase
      end
    end

    // end of record: a field still open is cut short, then restart
    if (last_byte) begin
      if (state_next.in_field && state_next.bytes_left != 3'd0) begin
        fire   = 1'b1;
        report = '{report_kind: KIND_TRUNCATED, channel: CHANNEL_ONE,
                   value_raw: 32'd0, rssi_dbm: 16'sd0, mains_powered: 1'b0};
      end
      state_next = '0;
    end
  end

endmodule

@@ rtl/tagged_record_field_extractor.sv @@
// top level of the tagged record field extractor
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_ready    payload_byte, last_byte
//  out      output     out_valid / out_ready  report_kind, channel, value_raw,
//                                             rssi_dbm, mains_powered
//
// one byte per cycle while in_ready is high; a report is registered into the output
// register at the transfer of the byte that completes its field
// the parse state is updated at the input transfer, so bytes follow back to back
// in_ready drops only while a report is held and out_ready is low
// rst is synchronous and returns the parser to expecting a tag
module tagged_record_field_extractor
  import tre_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         payload_byte,
  input  logic               last_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         report_kind,
  output logic [1:0]         channel,
  output logic [31:0]        value_raw,
  output logic signed [15:0] rssi_dbm,
  output logic               mains_powered
);

`include "tagged_record_field_extractor_defines.svh"

  parse_state_t state;
  parse_state_t state_next;
  logic         fire;
  report_t      report;
  logic         in_xfer;

  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;

  tre_decode u_decode (
    .state        (state),
    .payload_byte (payload_byte),
    .last_byte    (last_byte),
    .state_next   (state_next),
    .fire         (fire),
    .report       (report)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_xfer) begin
        state <= state_next;
      end
      if (in_xfer) begin
        out_valid <= fire;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && fire) begin
      report_kind   <= report.report_kind;
      channel       <= report.channel;
      value_raw     <= report.value_raw;
      rssi_dbm      <= report.rssi_dbm;
      mains_powered <= report.mains_powered;
    end
  end

  `TRE_ASSERT_NEXT(a_restart_after_last, in_xfer && last_byte, !state.in_field, "no restart after last byte")
  `TRE_ASSERT_NOW(a_open_field_has_bytes, state.in_field, state.bytes_left != 3'd0, "open field with no bytes left")
  `TRE_ASSERT_NOW(a_mains_on_voltage, out_valid && mains_powered, report_kind == KIND_VOLTAGE, "mains flag off a voltage report")
  `TRE_ASSERT_NOW(a_channel_two_switch, out_valid && channel == CHANNEL_TWO, report_kind == KIND_SWITCH, "channel two on a non-switch report")
  `TRE_ASSERT_NEXT(a_stall_holds_report, out_valid && !out_ready, out_valid && $stable(value_raw), "held report lost")

endmodule
